// ----- rtl/core/pmsc_pkg.sv -----
package pmsc_pkg;

	localparam int unsigned SPEED_W = 16;
	localparam int unsigned MAG_W   = 16;
	localparam int unsigned GAIN_W  = 12;
	localparam int unsigned PROD_W  = MAG_W + GAIN_W;
	localparam int unsigned CNT_W   = $clog2(PROD_W);
	localparam int unsigned DUTY_W  = 16;
	localparam int unsigned ACC_W   = 17;
	localparam int unsigned WIDE_W  = PROD_W + 2;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned DATA_W  = 16;

	localparam logic [IDX_W-1:0] REG_PROP_NUM = 3'd0;
	localparam logic [IDX_W-1:0] REG_PROP_DEN = 3'd1;
	localparam logic [IDX_W-1:0] REG_INT_NUM  = 3'd2;
	localparam logic [IDX_W-1:0] REG_INT_DEN  = 3'd3;
	localparam logic [IDX_W-1:0] REG_EN_SPEED = 3'd4;

	localparam logic [GAIN_W-1:0]  GAIN_RESET     = 12'd1;
	localparam logic [SPEED_W-1:0] EN_SPEED_RESET = 16'd30;

	typedef enum logic [1:0] {
		G_IDLE,
		G_MUL,
		G_DIV,
		G_DONE
	} gain_state_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_BUSY,
		ST_INTEG,
		ST_SUM
	} ctrl_state_t;

endpackage

// ----- rtl/core/pi_motor_speed_controller_top.sv -----
// PI speed controller with anti-windup: each accepted word (target and measured speed) yields
// one duty word. The two gain terms are formed in parallel by serial units, each a 12-step
// shift-and-add multiply followed by a 28-step restoring divide, and a new word is taken only
// once the current one is through. The result waits in an output register, and a new word
// is accepted while it waits. The user must write the gain registers only while the block
// is idle; the block itself does not enforce this. A divisor written as zero acts as one.
module pi_motor_speed_controller_top #(
	parameter int unsigned DUTY_MAX = 39999
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [pmsc_pkg::IDX_W-1:0]     wr_index,
	input  logic [pmsc_pkg::DATA_W-1:0]    wr_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [pmsc_pkg::SPEED_W-1:0]   target_speed,
	input  logic [pmsc_pkg::SPEED_W-1:0]   measured_speed,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [pmsc_pkg::DUTY_W-1:0]    duty
);
	import pmsc_pkg::*;

	localparam logic signed [WIDE_W-1:0] LIM     = WIDE_W'(DUTY_MAX);
	localparam logic signed [WIDE_W-1:0] NEG_LIM = -WIDE_W'(DUTY_MAX);

	ctrl_state_t              state_q;
	ctrl_state_t              state_d;
	logic [GAIN_W-1:0]        prop_num_q;
	logic [GAIN_W-1:0]        prop_den_q;
	logic [GAIN_W-1:0]        int_num_q;
	logic [GAIN_W-1:0]        int_den_q;
	logic [SPEED_W-1:0]       en_speed_q;
	logic [MAG_W-1:0]         mag_q;
	logic                     neg_q;
	logic                     hold_off_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  integ_q;
	logic                     out_valid_q;
	logic [DUTY_W-1:0]        duty_q;
	logic                     start;
	logic                     load_integ;
	logic                     finish;
	logic                     done_p;
	logic                     done_i;
	logic [PROD_W-1:0]        quot_p;
	logic [PROD_W-1:0]        quot_i;
	logic signed [WIDE_W-1:0] term_p;
	logic signed [WIDE_W-1:0] term_i;
	logic signed [WIDE_W-1:0] integ_sum;
	logic signed [WIDE_W-1:0] integ_clamp;
	logic signed [WIDE_W-1:0] total;
	logic [DUTY_W-1:0]        duty_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_num_q <= GAIN_RESET;
			prop_den_q <= GAIN_RESET;
			int_num_q  <= GAIN_RESET;
			int_den_q  <= GAIN_RESET;
			en_speed_q <= EN_SPEED_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PROP_NUM: prop_num_q <= wr_data[GAIN_W-1:0];
				REG_PROP_DEN: prop_den_q <= wr_data[GAIN_W-1:0];
				REG_INT_NUM:  int_num_q  <= wr_data[GAIN_W-1:0];
				REG_INT_DEN:  int_den_q  <= wr_data[GAIN_W-1:0];
				REG_EN_SPEED: en_speed_q <= wr_data[SPEED_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				state_d = ST_BUSY;
			end
			ST_BUSY: begin
				if (done_p && done_i) begin
					state_d = ST_INTEG;
				end
			end
			ST_INTEG: begin
				state_d = ST_SUM;
			end
			ST_SUM: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		start      = (state_q == ST_START);
		load_integ = (state_q == ST_INTEG);
		finish     = (state_q == ST_SUM) && (!out_valid_q || out_ready);
	end

	pmsc_gain u_prop (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mag    (mag_q),
		.num    (prop_num_q),
		.den    (prop_den_q),
		.done   (done_p),
		.quot   (quot_p)
	);

	pmsc_gain u_int (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mag    (mag_q),
		.num    (int_num_q),
		.den    (int_den_q),
		.done   (done_i),
		.quot   (quot_i)
	);

	// Magnitude division then sign restore gives truncation toward zero.
	assign term_p = neg_q ? -$signed({2'b00, quot_p}) : $signed({2'b00, quot_p});
	assign term_i = neg_q ? -$signed({2'b00, quot_i}) : $signed({2'b00, quot_i});

	always_comb begin
		integ_sum = term_i + WIDE_W'(acc_q);
		priority if (integ_sum < NEG_LIM) begin
			integ_clamp = NEG_LIM;
		end else if (integ_sum > LIM) begin
			integ_clamp = LIM;
		end else begin
			integ_clamp = integ_sum;
		end
	end

	always_comb begin
		total = term_p + WIDE_W'(integ_q);
		priority if (hold_off_q) begin
			duty_sat = '0;
		end else if (total > LIM) begin
			duty_sat = DUTY_W'(DUTY_MAX);
		end else if (total < 0) begin
			duty_sat = '0;
		end else begin
			duty_sat = total[DUTY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				acc_q       <= hold_off_q ? '0 : integ_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			neg_q      <= (measured_speed > target_speed);
			mag_q      <= (measured_speed > target_speed) ? (measured_speed - target_speed)
			                                              : (target_speed - measured_speed);
			hold_off_q <= (target_speed < en_speed_q);
		end
		if (load_integ) begin
			integ_q <= integ_clamp[ACC_W-1:0];
		end
		if (finish) begin
			duty_q <= duty_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign duty      = duty_q;

`ifndef NO_ASSERTIONS
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (duty <= DUTY_W'(DUTY_MAX)))
		else $error("duty word above limit");
	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(WIDE_W'(acc_q) <= LIM) && (WIDE_W'(acc_q) >= NEG_LIM))
		else $error("integral outside clamp range");
	a_hold_off_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && hold_off_q) |=> (acc_q == '0) && (duty == '0))
		else $error("held-off word left integral or duty nonzero");
	a_units_together: assert property (@(posedge clk) disable iff (!arst_n)
		done_p == done_i)
		else $error("gain units out of step");
`endif

endmodule

// ----- rtl/core/pmsc_gain.sv -----
module pmsc_gain (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pmsc_pkg::MAG_W-1:0]    mag,
	input  logic [pmsc_pkg::GAIN_W-1:0]   num,
	input  logic [pmsc_pkg::GAIN_W-1:0]   den,
	output logic                          done,
	output logic [pmsc_pkg::PROD_W-1:0]   quot
);
	import pmsc_pkg::*;

	gain_state_t        state_q;
	gain_state_t        state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic [MAG_W-1:0]   mag_q;
	logic [GAIN_W-1:0]  num_q;
	logic [GAIN_W-1:0]  den_q;
	logic [GAIN_W-1:0]  rem_q;
	logic [PROD_W-1:0]  acc_q;
	logic               mul_en;
	logic               div_en;
	logic               last;
	logic [GAIN_W:0]    trial;
	logic [GAIN_W:0]    diff;
	logic               qbit;

	assign last = (state_q == G_MUL) ? (cnt_q == CNT_W'(GAIN_W - 1))
	                                 : (cnt_q == CNT_W'(PROD_W - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			G_IDLE: begin
				if (start) begin
					state_d = G_MUL;
				end
			end
			G_MUL: begin
				if (last) begin
					state_d = G_DIV;
				end
			end
			G_DIV: begin
				if (last) begin
					state_d = G_DONE;
				end
			end
			G_DONE: begin
				state_d = G_IDLE;
			end
			default: begin
				state_d = G_IDLE;
			end
		endcase
	end

	always_comb begin
		mul_en = (state_q == G_MUL);
		div_en = (state_q == G_DIV);
		done   = (state_q == G_DONE);
	end

	// One quotient bit per cycle; the remainder always stays below the divisor.
	assign trial = {rem_q, acc_q[PROD_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign qbit  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (start && state_q == G_IDLE) begin
				cnt_q <= '0;
			end else if ((mul_en || div_en) && last) begin
				cnt_q <= '0;
			end else if (mul_en || div_en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == G_IDLE) begin
			mag_q <= mag;
			num_q <= num;
			den_q <= (den == '0) ? GAIN_W'(1) : den;
			acc_q <= '0;
		end else if (mul_en) begin
			acc_q <= {acc_q[PROD_W-2:0], 1'b0} + (num_q[GAIN_W-1] ? PROD_W'(mag_q) : '0);
			num_q <= {num_q[GAIN_W-2:0], 1'b0};
			if (last) begin
				rem_q <= '0;
			end
		end else if (div_en) begin
			rem_q <= qbit ? diff[GAIN_W-1:0] : trial[GAIN_W-1:0];
			acc_q <= {acc_q[PROD_W-2:0], qbit};
		end
	end

	assign quot = acc_q;

`ifndef NO_ASSERTIONS
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == G_DIV) |-> (rem_q < den_q))
		else $error("division remainder not below divisor");
	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");
`endif

endmodule
